// ===== src/qdc_pkg.sv =====
// shared types, codes and the quadrature transition decode for the decoder counter
package qdc_pkg;

    // operation codes carried by an input word
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_DELTA  = 2'd1,
        OP_COUNT  = 2'd2,
        OP_LOAD   = 2'd3
    } opcode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_SIGN,
        ST_MUL,
        ST_ADV,
        ST_DONE
    } state_t;

    // count direction from one phase transition
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic div_step;
        logic sign_fix;
        logic mul;
        logic advance;
        logic out_load;
    } qdc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        opcode_t opcode;
        logic    div_last;
        logic    out_free;
    } qdc_status_t;

    localparam int          DATA_W        = 32;
    localparam int          DIV_W         = 8;
    localparam int          CNT_W         = $clog2(DATA_W);
    localparam logic [DIV_W-1:0] DIVISOR_RESET = 8'd4;

    // x4 transition decode, index is {old phase, new phase}
    function automatic step_t step_of(input logic [3:0] idx);
        step_t s;
        s = STEP_NONE;
        case (idx) inside
            4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
            4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
            default:                  s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

// ===== src/qdc_ctrl.sv =====
// controller state machine sequencing one word through the datapath
module qdc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qdc_pkg::qdc_status_t status,
    output qdc_pkg::qdc_cmd_t    cmd
);

    qdc_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qdc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qdc_pkg::ST_IDLE: begin
                if (s_valid) state_next = qdc_pkg::ST_EXEC;
            end
            qdc_pkg::ST_EXEC: begin
                if (status.opcode inside {qdc_pkg::OP_SAMPLE, qdc_pkg::OP_LOAD})
                    state_next = qdc_pkg::ST_DONE;
                else
                    state_next = qdc_pkg::ST_DIV;
            end
            qdc_pkg::ST_DIV: begin
                if (status.div_last) state_next = qdc_pkg::ST_SIGN;
            end
            qdc_pkg::ST_SIGN: begin
                if (status.opcode == qdc_pkg::OP_DELTA)
                    state_next = qdc_pkg::ST_MUL;
                else
                    state_next = qdc_pkg::ST_DONE;
            end
            qdc_pkg::ST_MUL:  state_next = qdc_pkg::ST_ADV;
            qdc_pkg::ST_ADV:  state_next = qdc_pkg::ST_DONE;
            qdc_pkg::ST_DONE: begin
                if (status.out_free) state_next = qdc_pkg::ST_IDLE;
            end
            default: state_next = qdc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            qdc_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            qdc_pkg::ST_EXEC: cmd.execute  = 1'b1;
            qdc_pkg::ST_DIV:  cmd.div_step = 1'b1;
            qdc_pkg::ST_SIGN: cmd.sign_fix = 1'b1;
            qdc_pkg::ST_MUL:  cmd.mul      = 1'b1;
            qdc_pkg::ST_ADV:  cmd.advance  = 1'b1;
            qdc_pkg::ST_DONE: cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== src/qdc_dpath.sv =====
// datapath: counts, phase tracking, serial divider, shared multiplier and output register
module qdc_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qdc_pkg::qdc_cmd_t                   cmd,
    output qdc_pkg::qdc_status_t                status,
    input  logic                                cfg_wr_en,
    input  logic [qdc_pkg::DIV_W-1:0]           cfg_wr_data,
    input  logic [1:0]                          s_opcode,
    input  logic [1:0]                          s_pins,
    input  logic signed [qdc_pkg::DATA_W-1:0]   s_load_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qdc_pkg::DATA_W-1:0]   m_value
);

    localparam int W  = qdc_pkg::DATA_W;
    localparam int DW = qdc_pkg::DIV_W;
    localparam int CW = qdc_pkg::CNT_W;

    // captured word
    qdc_pkg::opcode_t op_reg, op_next;
    logic [1:0]       pins_reg, pins_next;
    logic [W-1:0]     load_reg, load_next;

    // counter state and configuration
    logic [1:0]       phase_reg, phase_next;
    logic             known_reg, known_next;
    logic [W-1:0]     raw_reg, raw_next;
    logic [W-1:0]     rep_reg, rep_next;
    logic [DW-1:0]    divisor_reg, divisor_next;

    // divider and result
    logic             neg_reg, neg_next;
    logic [W-1:0]     dq_reg, dq_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]     res_reg, res_next;
    logic [W-1:0]     prod_reg, prod_next;

    // output register
    logic [W-1:0]     out_value_reg, out_value_next;
    logic             out_valid_reg, out_valid_next;

    logic [DW-1:0]    d_eff;
    logic [W-1:0]     mul_full;
    logic [W-1:0]     mul_a;
    logic [W-1:0]     dividend;
    logic [DW:0]      trial;
    logic             trial_ge;
    logic [W-1:0]     raw_sample;
    qdc_pkg::step_t   step;

    // zero divisor acts as one
    assign d_eff = (divisor_reg == '0) ? DW'(1) : divisor_reg;

    // shared multiplier: load scaling or delta advance, wrapping at the count width
    assign mul_a    = cmd.execute ? load_reg : res_reg;
    assign mul_full = mul_a * W'(d_eff);

    // dividend for the scaled reads
    assign dividend = (op_reg == qdc_pkg::OP_DELTA) ? (raw_reg - rep_reg) : raw_reg;

    // one restoring divide step
    assign trial    = {rem_reg, dq_reg[W-1]};
    assign trial_ge = trial >= {1'b0, d_eff};

    // phase transition decode
    assign step = qdc_pkg::step_of({phase_reg, pins_reg});
    always_comb begin
        raw_sample = raw_reg;
        if (known_reg && pins_reg != phase_reg) begin
            case (step)
                qdc_pkg::STEP_UP:   raw_sample = raw_reg + W'(1);
                qdc_pkg::STEP_DOWN: raw_sample = raw_reg - W'(1);
                default:            raw_sample = raw_reg;
            endcase
        end
    end

    // next values
    always_comb begin
        op_next        = op_reg;
        pins_next      = pins_reg;
        load_next      = load_reg;
        phase_next     = phase_reg;
        known_next     = known_reg;
        raw_next       = raw_reg;
        rep_next       = rep_reg;
        divisor_next   = divisor_reg;
        neg_next       = neg_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        prod_next      = prod_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg;

        if (cfg_wr_en) divisor_next = cfg_wr_data;

        // take the input word
        if (cmd.capture) begin
            op_next   = qdc_pkg::opcode_t'(s_opcode);
            pins_next = s_pins;
            load_next = s_load_value;
        end

        // first step of every operation
        if (cmd.execute) begin
            case (op_reg)
                qdc_pkg::OP_SAMPLE: begin
                    phase_next = pins_reg;
                    known_next = 1'b1;
                    raw_next   = raw_sample;
                    res_next   = raw_sample;
                end
                qdc_pkg::OP_LOAD: begin
                    raw_next = mul_full;
                    rep_next = mul_full;
                    res_next = '0;
                end
                default: begin
                    neg_next = dividend[W-1];
                    dq_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
                    rem_next = '0;
                    cnt_next = '0;
                end
            endcase
        end

        // divider iteration
        if (cmd.div_step) begin
            rem_next = trial_ge ? DW'(trial - {1'b0, d_eff}) : trial[DW-1:0];
            dq_next  = {dq_reg[W-2:0], trial_ge};
            cnt_next = cnt_reg + CW'(1);
        end

        // restore the sign of the quotient
        if (cmd.sign_fix) res_next = neg_reg ? (W'(0) - dq_reg) : dq_reg;

        // whole steps times divisor, then advance the reported count
        if (cmd.mul)     prod_next = mul_full;
        if (cmd.advance) rep_next  = rep_reg + prod_reg;

        // output register
        if (cmd.out_load) begin
            out_value_next = res_reg;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and count state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            known_reg     <= 1'b0;
            raw_reg       <= '0;
            rep_reg       <= '0;
            divisor_reg   <= qdc_pkg::DIVISOR_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= qdc_pkg::OP_SAMPLE;
        end else begin
            phase_reg     <= phase_next;
            known_reg     <= known_next;
            raw_reg       <= raw_next;
            rep_reg       <= rep_next;
            divisor_reg   <= divisor_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pins_reg      <= pins_next;
        load_reg      <= load_next;
        neg_reg       <= neg_next;
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        prod_reg      <= prod_next;
        out_value_reg <= out_value_next;
    end

    // status back to the controller
    assign status.opcode   = op_reg;
    assign status.div_last = (cnt_reg == CW'(W - 1));
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_value = out_value_reg;

endmodule

// ===== src/quadrature_decoder_counter.sv =====
// Sequence: pin sample and load run accept, execute, then the output load; count read adds
// the 32-step one-bit-per-cycle divider and a sign fix, and delta read also multiply and advance.
// Handshake: one word at a time; the next word is accepted in the cycle after the result
// enters the output register, which may still be waiting on m_ready.
// Reset (aresetn low, synchronous): counts, phase and output valid clear, divisor returns to 4.
module quadrature_decoder_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [qdc_pkg::DIV_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [1:0]                          s_pins,
    input  logic signed [qdc_pkg::DATA_W-1:0]   s_load_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qdc_pkg::DATA_W-1:0]   m_value
);

    qdc_pkg::qdc_cmd_t    cmd;
    qdc_pkg::qdc_status_t status;

    // sequencer
    qdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // counts, divider and output register
    qdc_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_opcode     (s_opcode),
        .s_pins       (s_pins),
        .s_load_value (s_load_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

endmodule
